// ===== src/rsmr_pkg.sv =====
`timescale 1ns / 1ps

package rsmr_pkg;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_APPLY = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] SHAPE_SQUARE   = 2'd0;
   localparam logic [1:0] SHAPE_CIRCLE   = 2'd1;
   localparam logic [1:0] SHAPE_TRIANGLE = 2'd2;

   localparam logic signed [2:0] ORIENT_UP    = 3'sd1;
   localparam logic signed [2:0] ORIENT_DOWN  = -3'sd1;
   localparam logic signed [2:0] ORIENT_RIGHT = 3'sd2;
   localparam logic signed [2:0] ORIENT_LEFT  = -3'sd2;

   localparam int MASK_WORD_BITS = 32;
   localparam int BIT_SEL_W      = 5;
   localparam int COUNT_W        = 21;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef logic signed [23:0] term_type;
   typedef logic signed [13:0] coord_type;
   typedef logic signed [27:0] lin_type;
   typedef logic [MASK_WORD_BITS-1:0] mask_word_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_DRAIN,
      ST_READ_ISSUE,
      ST_READ_WAIT,
      ST_RESP
   } rsmr_state_type;

   typedef struct packed {
      logic [1:0]        shape;
      logic signed [2:0] orientation;
      logic              a_zero;
      logic              left_half;
      term_type          a;
      term_type          aa;
      term_type          ab;
      term_type          sqx;
      term_type          sqy;
      term_type          ya;
      term_type          bx;
   } shape_terms_type;

endpackage

// ===== src/roi_shape_mask_rasterizer.sv =====
`timescale 1ns / 1ps

// Keeps a one-bit enable mask per sensor pixel in a single 32-bit-wide RAM and
// handles one command word at a time. Applying a region first forms the setup
// terms (the squares and product of the half sizes, and the row base), then
// walks every pixel of its (2*half_width+1) x (2*half_height+1) bounding box,
// then drains the read-modify-write pipeline and posts the result. Clearing
// rewrites the RAM one word per cycle, and the same clearing pass runs after
// reset before the first command word is accepted. A mask read issues the RAM
// read, waits for the registered read data and posts the bit. The next command
// word is taken while the previous result still waits in the output register.

module roi_shape_mask_rasterizer import rsmr_pkg::*; #(
   parameter int SENSOR_WIDTH  = 1024,
   parameter int SENSOR_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // shape, orientation, half_width, half_height, centre_x, centre_y, pixel_index
   input  logic [63:0] req_tdata,
   // cmd
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // newly_masked, total_masked, clipped, mask_bit
   output logic [47:0] rsp_tdata
);

   localparam int PIXELS = SENSOR_WIDTH * SENSOR_HEIGHT;
   localparam int WORDS  = (PIXELS + MASK_WORD_BITS - 1) / MASK_WORD_BITS;
   localparam int ADDR_W = $clog2(WORDS);
   localparam int PIX_W  = ADDR_W + BIT_SEL_W;
   localparam int EXT_W  = PIX_W + 20;
   localparam logic [EXT_W-1:0] PIXELS_X = EXT_W'(PIXELS);
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS - 1);
   localparam coord_type SENSOR_W_S = coord_type'(SENSOR_WIDTH);
   localparam coord_type SENSOR_H_S = coord_type'(SENSOR_HEIGHT);

   rsmr_state_type state_ff, state_in;

   logic [1:0]        shape_ff, shape_in;
   logic signed [2:0] orient_ff, orient_in;
   logic [8:0]        a_ff, a_in, b_ff, b_in;
   logic [19:0]       pidx_ff, pidx_in;
   coord_type         x0_ff, x0_in, y0_ff, y0_in;
   logic              clr_cmd_ff, clr_cmd_in;
   logic [1:0]        step_ff, step_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   term_type          aa_ff, aa_in, bb_ff, bb_in, ab_ff, ab_in;

   logic [9:0]        x_ff, x_in, y_ff, y_in;
   coord_type         col_ff, col_in, row_ff, row_in, dx_ff, dx_in, dy_ff, dy_in;
   term_type          sqx_ff, sqx_in, sqy_ff, sqy_in, ya_ff, ya_in, bx_ff, bx_in;
   lin_type           row_base_ff, row_base_in;

   logic              p1_valid_ff, p1_valid_in;
   logic [ADDR_W-1:0] p1_addr_ff, p1_addr_in;
   logic [BIT_SEL_W-1:0] p1_bit_ff, p1_bit_in;
   logic              last_wr_valid_ff;
   logic [ADDR_W-1:0] last_wr_addr_ff;
   mask_word_type     last_wr_data_ff;

   logic [COUNT_W-1:0] newly_ff, newly_in, masked_ff, masked_in;
   logic               clipped_ff, clipped_in, bit_ff, bit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_newly_ff, rsp_newly_in, rsp_total_ff, rsp_total_in;
   logic               rsp_clipped_ff, rsp_clipped_in, rsp_bit_ff, rsp_bit_in;

   logic              req_fire;
   logic [1:0]        in_cmd;
   logic [8:0]        in_a, in_b;
   logic [9:0]        in_cx, in_cy;
   coord_type         a_c, b_c;
   term_type          a_t, b_t;
   logic signed [13:0] mul_a, mul_b;
   lin_type           mul_p;
   logic              last_col, last_row, on_sensor, shape_hit, walk_hit;
   lin_type           lin;
   logic [PIX_W-1:0]  pix;
   logic [EXT_W-1:0]  pidx_ext;
   shape_terms_type   terms;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   mask_word_type     ram_wr_data, ram_rd_data, cur_word;
   logic              old_bit, p1_clear;

   rsmr_ram #(
      .WIDTH (MASK_WORD_BITS),
      .DEPTH (WORDS)
   ) u_mask_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rsmr_shape_test u_shape_test (
      .terms (terms),
      .hit   (shape_hit)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign in_cmd     = req_tuser;
   assign in_a       = req_tdata[13:5];
   assign in_b       = req_tdata[22:14];
   assign in_cx      = req_tdata[32:23];
   assign in_cy      = req_tdata[42:33];

   assign a_c = {5'b0, a_ff};
   assign b_c = {5'b0, b_ff};
   assign a_t = {15'b0, a_ff};
   assign b_t = {15'b0, b_ff};

   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_a = a_c;
            mul_b = a_c;
         end
         2'd1: begin
            mul_a = b_c;
            mul_b = b_c;
         end
         2'd2: begin
            mul_a = a_c;
            mul_b = b_c;
         end
         default: begin
            mul_a = y0_ff;
            mul_b = SENSOR_W_S;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   assign last_col  = (x_ff == {a_ff, 1'b0});
   assign last_row  = (y_ff == {b_ff, 1'b0});
   assign on_sensor = (row_ff >= 0) && (row_ff < SENSOR_H_S)
                      && (col_ff >= 0) && (col_ff < SENSOR_W_S);
   assign lin       = row_base_ff + lin_type'(col_ff);
   assign pix       = lin[PIX_W-1:0];
   assign pidx_ext  = EXT_W'(pidx_ff);

   always_comb begin
      terms.shape       = shape_ff;
      terms.orientation = orient_ff;
      terms.a_zero      = (a_ff == '0);
      terms.left_half   = (dx_ff <= 0);
      terms.a           = a_t;
      terms.aa          = aa_ff;
      terms.ab          = ab_ff;
      terms.sqx         = sqx_ff;
      terms.sqy         = sqy_ff;
      terms.ya          = ya_ff;
      terms.bx          = bx_ff;
   end

   assign walk_hit    = (state_ff == ST_WALK) && on_sensor && shape_hit;
   assign ram_rd_addr = (state_ff == ST_WALK) ? pix[PIX_W-1:BIT_SEL_W]
                                              : pidx_ext[PIX_W-1:BIT_SEL_W];

   // The read for a pixel was issued before the previous cycle's write landed.
   assign cur_word = (last_wr_valid_ff && (last_wr_addr_ff == p1_addr_ff))
                     ? last_wr_data_ff : ram_rd_data;
   assign old_bit  = cur_word[p1_bit_ff];
   assign p1_clear = p1_valid_ff && old_bit;

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '1;
      end else begin
         ram_wr_en   = p1_clear;
         ram_wr_addr = p1_addr_ff;
         ram_wr_data = cur_word & ~(mask_word_type'(1) << p1_bit_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      shape_in     = shape_ff;
      orient_in    = orient_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      pidx_in      = pidx_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      clr_cmd_in   = clr_cmd_ff;
      step_in      = step_ff;
      clr_addr_in  = clr_addr_ff;
      aa_in        = aa_ff;
      bb_in        = bb_ff;
      ab_in        = ab_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      ya_in        = ya_ff;
      bx_in        = bx_ff;
      row_base_in  = row_base_ff;
      p1_valid_in  = walk_hit;
      p1_addr_in   = pix[PIX_W-1:BIT_SEL_W];
      p1_bit_in    = pix[BIT_SEL_W-1:0];
      newly_in     = newly_ff;
      masked_in    = masked_ff;
      clipped_in   = clipped_ff;
      bit_in       = bit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_newly_in   = rsp_newly_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_clipped_in = rsp_clipped_ff;
      rsp_bit_in     = rsp_bit_ff;

      if (p1_clear) begin
         if (newly_ff != COUNT_MAX) begin
            newly_in = newly_ff + COUNT_W'(1);
         end
         if (masked_ff != COUNT_MAX) begin
            masked_in = masked_ff + COUNT_W'(1);
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_WORD) begin
               clr_addr_in = '0;
               state_in    = clr_cmd_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               shape_in   = req_tdata[1:0];
               orient_in  = req_tdata[4:2];
               a_in       = in_a;
               b_in       = in_b;
               pidx_in    = req_tdata[62:43];
               x0_in      = coord_type'({4'b0, in_cx}) - coord_type'({5'b0, in_a});
               y0_in      = coord_type'({4'b0, in_cy}) - coord_type'({5'b0, in_b});
               step_in    = '0;
               newly_in   = '0;
               clipped_in = 1'b0;
               bit_in     = 1'b0;
               case (in_cmd)
                  CMD_CLEAR: begin
                     masked_in   = '0;
                     clr_cmd_in  = 1'b1;
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  CMD_APPLY: begin
                     state_in = ST_SETUP;
                  end
                  CMD_READ: begin
                     state_in = ST_READ_ISSUE;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd0: begin
                  aa_in = term_type'(mul_p);
               end
               2'd1: begin
                  bb_in = term_type'(mul_p);
               end
               2'd2: begin
                  ab_in = term_type'(mul_p);
               end
               default: begin
                  row_base_in = mul_p;
                  x_in        = '0;
                  y_in        = '0;
                  col_in      = x0_ff;
                  row_in      = y0_ff;
                  dx_in       = -a_c;
                  dy_in       = -b_c;
                  sqx_in      = aa_ff;
                  sqy_in      = bb_ff;
                  ya_in       = '0;
                  bx_in       = '0;
                  clipped_in  = (x0_ff < 0) || (y0_ff < 0)
                                || (x0_ff + (a_c <<< 1) >= SENSOR_W_S)
                                || (y0_ff + (b_c <<< 1) >= SENSOR_H_S);
                  state_in    = ST_WALK;
               end
            endcase
         end
         ST_WALK: begin
            if (last_col) begin
               if (last_row) begin
                  state_in = ST_DRAIN;
               end else begin
                  x_in        = '0;
                  col_in      = x0_ff;
                  dx_in       = -a_c;
                  sqx_in      = aa_ff;
                  bx_in       = '0;
                  y_in        = y_ff + 10'd1;
                  row_in      = row_ff + coord_type'(1);
                  row_base_in = row_base_ff + lin_type'(SENSOR_W_S);
                  dy_in       = dy_ff + coord_type'(1);
                  sqy_in      = sqy_ff + (term_type'(dy_ff) <<< 1) + term_type'(1);
                  ya_in       = ya_ff + a_t;
               end
            end else begin
               x_in   = x_ff + 10'd1;
               col_in = col_ff + coord_type'(1);
               dx_in  = dx_ff + coord_type'(1);
               sqx_in = sqx_ff + (term_type'(dx_ff) <<< 1) + term_type'(1);
               bx_in  = bx_ff + b_t;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_READ_ISSUE: begin
            state_in = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            bit_in   = (pidx_ext < PIXELS_X) ? ram_rd_data[pidx_ff[BIT_SEL_W-1:0]] : 1'b0;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_newly_in   = newly_ff;
               rsp_total_in   = masked_ff;
               rsp_clipped_in = clipped_ff;
               rsp_bit_in     = bit_ff;
               clr_cmd_in     = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_cmd_ff       <= 1'b0;
         clr_addr_ff      <= '0;
         step_ff          <= '0;
         p1_valid_ff      <= 1'b0;
         last_wr_valid_ff <= 1'b0;
         masked_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_cmd_ff       <= clr_cmd_in;
         clr_addr_ff      <= clr_addr_in;
         step_ff          <= step_in;
         p1_valid_ff      <= p1_valid_in;
         last_wr_valid_ff <= ram_wr_en;
         masked_ff        <= masked_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shape_ff        <= shape_in;
      orient_ff       <= orient_in;
      a_ff            <= a_in;
      b_ff            <= b_in;
      pidx_ff         <= pidx_in;
      x0_ff           <= x0_in;
      y0_ff           <= y0_in;
      aa_ff           <= aa_in;
      bb_ff           <= bb_in;
      ab_ff           <= ab_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      col_ff          <= col_in;
      row_ff          <= row_in;
      dx_ff           <= dx_in;
      dy_ff           <= dy_in;
      sqx_ff          <= sqx_in;
      sqy_ff          <= sqy_in;
      ya_ff           <= ya_in;
      bx_ff           <= bx_in;
      row_base_ff     <= row_base_in;
      p1_addr_ff      <= p1_addr_in;
      p1_bit_ff       <= p1_bit_in;
      last_wr_addr_ff <= ram_wr_addr;
      last_wr_data_ff <= ram_wr_data;
      newly_ff        <= newly_in;
      clipped_ff      <= clipped_in;
      bit_ff          <= bit_in;
      rsp_newly_ff    <= rsp_newly_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_clipped_ff  <= rsp_clipped_in;
      rsp_bit_ff      <= rsp_bit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_bit_ff, rsp_clipped_ff, rsp_total_ff, rsp_newly_ff};

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !p1_valid_ff)
      else $error("pixel still in flight while a new command word can be taken");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && (in_cmd == CMD_CLEAR)) |=> masked_ff >= $past(masked_ff))
      else $error("masked count went down without a clear");

   a_newly_within_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_newly_ff <= rsp_total_ff)
      else $error("newly masked count exceeds total masked count");

endmodule

// ===== src/rsmr_ram.sv =====
`timescale 1ns / 1ps

module rsmr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rsmr_shape_test.sv =====
`timescale 1ns / 1ps

module rsmr_shape_test import rsmr_pkg::*; (
   input  shape_terms_type terms,
   output logic            hit
);

   always_comb begin
      term_type ay2;
      term_type bx2;
      term_type ab2;
      term_type ab4;
      term_type ya_dn;
      term_type ya_up;
      ay2   = terms.ya <<< 1;
      bx2   = terms.bx <<< 1;
      ab2   = terms.ab <<< 1;
      ab4   = terms.ab <<< 2;
      ya_dn = terms.ya - terms.a;
      ya_up = terms.ya + terms.a;
      hit   = 1'b0;
      case (terms.shape)
         SHAPE_SQUARE: begin
            hit = 1'b1;
         end
         SHAPE_CIRCLE: begin
            hit = (terms.sqx + terms.sqy) <= terms.aa;
         end
         SHAPE_TRIANGLE: begin
            if (!terms.a_zero) begin
               case (terms.orientation)
                  ORIENT_UP: begin
                     hit = terms.left_half ? (ya_dn < bx2) : (ya_dn < ab4 - bx2);
                  end
                  ORIENT_DOWN: begin
                     hit = terms.left_half ? (ya_up > ab2 - bx2) : (ya_up > bx2 - ab2);
                  end
                  ORIENT_RIGHT: begin
                     hit = (ay2 > terms.bx) && (ay2 < ab4 - terms.bx);
                  end
                  ORIENT_LEFT: begin
                     hit = (ay2 > ab2 - terms.bx) && (ay2 < ab2 + terms.bx);
                  end
                  default: begin
                     hit = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

endmodule
